@@ sv/bsd_pkg.sv @@
// bsd_pkg: shared types, codes and the control store for the bounded stack
// with sorted dump; used by bsd_seq, bsd_dp and the top level
`default_nettype none

package bsd_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

  // mode codes
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_DUMP  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_PUSH      = 4'd2;
  localparam logic [3:0] OP_POP_RD    = 4'd3;
  localparam logic [3:0] OP_POP_RES   = 4'd4;
  localparam logic [3:0] OP_CLEAR     = 4'd5;
  localparam logic [3:0] OP_DUMP_INIT = 4'd6;
  localparam logic [3:0] OP_SCAN_INIT = 4'd7;
  localparam logic [3:0] OP_SCAN      = 4'd8;
  localparam logic [3:0] OP_DUMP_RES  = 4'd9;
  localparam logic [3:0] OP_EMIT      = 4'd10;

  // branch conditions
  localparam logic [2:0] C_NEVER     = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_ITEM      = 3'd2;
  localparam logic [2:0] C_OUT_BUSY  = 3'd3;
  localparam logic [2:0] C_EMPTY     = 3'd4;
  localparam logic [2:0] C_SCAN_MORE = 3'd5;
  localparam logic [2:0] C_DUMP_MORE = 3'd6;

  // program steps
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PUSH     = 4'd1;
  localparam logic [3:0] S_EMIT     = 4'd2;
  localparam logic [3:0] S_POP_RD   = 4'd3;
  localparam logic [3:0] S_POP_RES  = 4'd4;
  localparam logic [3:0] S_CLEAR    = 4'd5;
  localparam logic [3:0] S_DUMP     = 4'd6;
  localparam logic [3:0] S_SCAN0    = 4'd7;
  localparam logic [3:0] S_SCAN     = 4'd8;
  localparam logic [3:0] S_DRES     = 4'd9;
  localparam logic [3:0] S_DEMIT    = 4'd10;
  localparam logic [3:0] S_DNEXT    = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cond;
    logic [3:0] target;
    logic       ret;     // fall back to idle when the branch is not taken
  } ucw_t;

  typedef struct packed {
    logic out_busy;
    logic empty;
    logic full;
    logic scan_more;
    logic dump_more;
  } bsd_flags_t;

  function automatic ucw_t ucode(input logic [3:0] step);
    ucw_t w;
    unique case (step)
      S_IDLE:    w = '{op: OP_LOAD,      cond: C_ITEM,      target: S_IDLE,  ret: 1'b0};
      S_PUSH:    w = '{op: OP_PUSH,      cond: C_NEVER,     target: S_IDLE,  ret: 1'b0};
      S_EMIT:    w = '{op: OP_EMIT,      cond: C_OUT_BUSY,  target: S_EMIT,  ret: 1'b1};
      S_POP_RD:  w = '{op: OP_POP_RD,    cond: C_NEVER,     target: S_IDLE,  ret: 1'b0};
      S_POP_RES: w = '{op: OP_POP_RES,   cond: C_ALWAYS,    target: S_EMIT,  ret: 1'b0};
      S_CLEAR:   w = '{op: OP_CLEAR,     cond: C_ALWAYS,    target: S_EMIT,  ret: 1'b0};
      S_DUMP:    w = '{op: OP_DUMP_INIT, cond: C_EMPTY,     target: S_EMIT,  ret: 1'b0};
      S_SCAN0:   w = '{op: OP_SCAN_INIT, cond: C_NEVER,     target: S_IDLE,  ret: 1'b0};
      S_SCAN:    w = '{op: OP_SCAN,      cond: C_SCAN_MORE, target: S_SCAN,  ret: 1'b0};
      S_DRES:    w = '{op: OP_DUMP_RES,  cond: C_NEVER,     target: S_IDLE,  ret: 1'b0};
      S_DEMIT:   w = '{op: OP_EMIT,      cond: C_OUT_BUSY,  target: S_DEMIT, ret: 1'b0};
      S_DNEXT:   w = '{op: OP_NONE,      cond: C_DUMP_MORE, target: S_SCAN0, ret: 1'b1};
      default:   w = '{op: OP_NONE,      cond: C_ALWAYS,    target: S_IDLE,  ret: 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] dispatch(input logic [1:0] mode);
    logic [3:0] s;
    unique case (mode)
      MODE_PUSH:  s = S_PUSH;
      MODE_POP:   s = S_POP_RD;
      MODE_CLEAR: s = S_CLEAR;
      MODE_DUMP:  s = S_DUMP;
      default:    s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/bsd_seq.sv @@
// bsd_seq: step counter and control store walk with conditional branches
// depends on bsd_pkg
`default_nettype none

module bsd_seq import bsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] mode,
  input  wire bsd_flags_t flags,
  output logic [3:0]      op,
  output logic            idle
);

  logic [3:0] step_r;
  logic [3:0] step_nxt;
  ucw_t       cw;
  logic       taken;

  assign cw   = ucode(step_r);
  assign op   = cw.op;
  assign idle = (step_r == S_IDLE);

  always_comb begin
    unique case (cw.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_ITEM:      taken = in_valid;
      C_OUT_BUSY:  taken = flags.out_busy;
      C_EMPTY:     taken = flags.empty;
      C_SCAN_MORE: taken = flags.scan_more;
      C_DUMP_MORE: taken = flags.dump_more;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    if (cw.cond == C_ITEM) begin
      step_nxt = taken ? dispatch(mode) : step_r;
    end else if (taken) begin
      step_nxt = cw.target;
    end else if (cw.ret) begin
      step_nxt = S_IDLE;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/bsd_dp.sv @@
// bsd_dp: stack memory, count, min-scan registers and output register
// driven by the operation code from bsd_seq; depends on bsd_pkg
`default_nettype none

module bsd_dp import bsd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [3:0] op,
  input  wire logic       in_valid,
  input  wire in_item_t   in_data,
  input  wire logic       out_stall,
  output logic            out_valid,
  output out_item_t       out_data,
  output bsd_flags_t      flags
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  logic [IW-1:0]      rd_addr;

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      cnt_m1;
  logic signed [31:0] val_r;
  logic [IW-1:0]      scan_r;
  logic [IW-1:0]      cmp_r;
  logic signed [31:0] best_v_r;
  logic [IW-1:0]      best_i_r;
  logic               have_best_r;
  logic signed [31:0] prev_v_r;
  logic [IW-1:0]      prev_i_r;
  logic               have_prev_r;
  logic [CW-1:0]      k_r;
  out_item_t          res_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic full, empty, out_busy, eligible, better;

  assign cnt_m1   = count_r - CW'(1);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign out_busy = out_valid_r && out_stall;

  assign flags.out_busy  = out_busy;
  assign flags.empty     = empty;
  assign flags.full      = full;
  assign flags.scan_more = (CW'(cmp_r) != cnt_m1);
  assign flags.dump_more = (k_r != count_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // entry order is (value, index); next output is the smallest entry above the last one
  assign eligible = !have_prev_r || (rdata_r > prev_v_r) ||
                    ((rdata_r == prev_v_r) && (cmp_r > prev_i_r));
  assign better   = !have_best_r || (rdata_r < best_v_r);

  always_comb begin
    case (op)
      OP_POP_RD:    rd_addr = cnt_m1[IW-1:0];
      OP_SCAN_INIT: rd_addr = '0;
      default:      rd_addr = scan_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (op == OP_PUSH && !full) begin
      mem[count_r[IW-1:0]] <= val_r;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (op)
        OP_PUSH:    if (!full) count_r <= count_r + CW'(1);
        OP_POP_RES: if (!empty) count_r <= cnt_m1;
        OP_CLEAR:   count_r <= '0;
        default:    ;
      endcase
      if (op == OP_EMIT && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (in_valid) val_r <= in_data.push_value;
      end
      OP_PUSH: begin
        res_r.status    <= full ? ST_FULL : ST_OK;
        res_r.out_value <= '0;
        res_r.last      <= 1'b1;
      end
      OP_POP_RES: begin
        res_r.status    <= empty ? ST_EMPTY : ST_OK;
        res_r.out_value <= empty ? 32'sd0 : rdata_r;
        res_r.last      <= 1'b1;
      end
      OP_CLEAR: begin
        res_r.status    <= ST_OK;
        res_r.out_value <= '0;
        res_r.last      <= 1'b1;
      end
      OP_DUMP_INIT: begin
        // only sent when the stack is empty
        res_r.status    <= ST_EMPTY;
        res_r.out_value <= '0;
        res_r.last      <= 1'b1;
        k_r             <= '0;
        have_prev_r     <= 1'b0;
      end
      OP_SCAN_INIT: begin
        scan_r      <= IW'(1);
        cmp_r       <= '0;
        have_best_r <= 1'b0;
      end
      OP_SCAN: begin
        if (eligible && better) begin
          best_v_r    <= rdata_r;
          best_i_r    <= cmp_r;
          have_best_r <= 1'b1;
        end
        cmp_r  <= scan_r;
        scan_r <= scan_r + IW'(1);
      end
      OP_DUMP_RES: begin
        res_r.status    <= ST_OK;
        res_r.out_value <= best_v_r;
        res_r.last      <= ((k_r + CW'(1)) == count_r);
        prev_v_r        <= best_v_r;
        prev_i_r        <= best_i_r;
        have_prev_r     <= 1'b1;
        k_r             <= k_r + CW'(1);
      end
      OP_EMIT: begin
        if (!out_busy) out_data_r <= res_r;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/bounded_stack_with_sorted_dump.sv @@
// bounded_stack_with_sorted_dump: bounded signed LIFO with push, pop, clear
// and an ascending dump. Input beats carry mode and push_value; result beats
// carry status, out_value and last, with last set on the final beat of each
// input beat. Both channels hand over a beat when valid is high and stall low.
// Control is a small microprogram (bsd_seq) over a datapath with one
// registered-read port memory (bsd_dp).
// Push, clear and an empty dump pass through their own step to the emit
// step; pop has a memory read step and a result step before its emit step.
// One input beat is taken at a time; the next is taken when the program is
// back in idle. A dump of n entries finds each output by scanning all n
// entries through the single memory read port; an empty dump gives one
// result.
// A stalled result beat holds in the output register. The next input can
// still be taken; the program then waits on that beat's emit step until
// the held beat is taken. Reset empties the stack and drops out_valid;
// memory contents are not cleared and no unwritten entry reaches a result.
`default_nettype none

module bounded_stack_with_sorted_dump import bsd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic [3:0] op;
  logic       idle;
  bsd_flags_t flags;

  assign in_stall = !idle;

  bsd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .mode     (in_data.mode),
    .flags    (flags),
    .op       (op),
    .idle     (idle)
  );

  bsd_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .flags     (flags)
  );

  // the block is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous beat in progress");

  // push on a full stack leaves it full
  a_full_push_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.mode == MODE_PUSH && flags.full) |-> ##2 flags.full)
    else $error("push on full stack changed the count");

  // clear empties the stack
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.mode == MODE_CLEAR) |-> ##2 flags.empty)
    else $error("stack not empty after clear");

endmodule

`default_nettype wire

@@ tb/sv/bsd_stack_watch.sv @@
// bsd_stack_watch: watches both channels of bounded_stack_with_sorted_dump,
// keeps its own copy of the stack and checks every result beat against it
// depends on bsd_pkg for the beat types and the mode and status codes
module bsd_stack_watch import bsd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatches,
  output int        due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] stack_words [DEPTH];
  int                 depth_used;
  out_item_t          due_beats [$];
  int                 errs;

  // works out the result beats of one input beat and updates the stack copy
  task automatic apply_stack_op(input in_item_t beat);
    logic signed [31:0] sorted [DEPTH];
    logic signed [31:0] key;
    int                 j;
    out_item_t          res;
    res = '0;
    res.status = ST_OK;
    res.last = 1'b1;
    case (beat.mode)
      MODE_PUSH: begin
        if (depth_used >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_words[depth_used] = beat.push_value;
          depth_used++;
        end
      end
      MODE_POP: begin
        if (depth_used == 0) begin
          res.status = ST_EMPTY;
        end else begin
          depth_used--;
          res.out_value = stack_words[depth_used];
        end
      end
      MODE_CLEAR: begin
        depth_used = 0;
      end
      MODE_DUMP: begin
        if (depth_used == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < depth_used; i++) sorted[i] = stack_words[i];
          // ascending signed order, duplicates kept
          for (int i = 1; i < depth_used; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j - 1] > key) begin
              sorted[j] = sorted[j - 1];
              j--;
            end
            sorted[j] = key;
          end
          for (int i = 0; i < depth_used; i++) begin
            res.out_value = sorted[i];
            res.last = (i == depth_used - 1);
            due_beats.push_back(res);
          end
          return;
        end
      end
    endcase
    due_beats.push_back(res);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      depth_used = 0;
      errs = 0;
      due_beats.delete();
    end else begin
      // results first: a beat accepted on this edge never belongs to the
      // input beat accepted on the same edge
      if (out_valid && !out_stall) begin
        if (due_beats.size() == 0) begin
          $error("unexpected result beat: status %0d out_value %0d last %0b",
                 out_data.status, $signed(out_data.out_value), out_data.last);
          errs++;
        end else begin
          want = due_beats.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errs++;
          end
          if (out_data.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d",
                   $signed(want.out_value), $signed(out_data.out_value));
            errs++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) apply_stack_op(in_data);
    end
    mismatches <= errs;
    due_count <= due_beats.size();
  end

endmodule

@@ tb/sv/bounded_stack_with_sorted_dump_test.sv @@
// bounded_stack_with_sorted_dump_test: clock, reset and stimulus for the
// bounded stack with sorted dump, with random gaps and stalls on both sides
// depends on bsd_pkg, the block itself and bsd_stack_watch for the checks
module bounded_stack_with_sorted_dump_test;
  import bsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH    = 16;
  localparam int RANDOM_ITEMS   = 430;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int mismatches;
  int due_count;
  int sent = 0;
  int stuck_cycles = 0;
  bit calm = 1'b0;

  always #1 clk = ~clk;

  bounded_stack_with_sorted_dump #(.DEPTH(STACK_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  bsd_stack_watch #(.DEPTH(STACK_DEPTH)) watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .due_count  (due_count)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(0, 8)) - 4;  // small range for duplicates
      4: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] mode, input logic signed [31:0] word);
    int gap;
    in_item_t beat;
    gap = calm ? 0 : pick_gap();
    beat.mode = mode;
    beat.push_value = word;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  initial begin : out_stall_gen
    int stall_len;
    int flow_len;
    @(posedge clk);
    forever begin
      stall_len = calm ? 0 : pick_gap();
      flow_len = $urandom_range(1, 12);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (flow_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin : watchdog
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("bounded_stack_with_sorted_dump: mismatch");
    $finish;
  end

  initial begin : stimulus
    int burst;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack, extremes, duplicates, then clear
    send_beat(MODE_DUMP, 32'sd0);
    send_beat(MODE_POP, 32'sd5);
    send_beat(MODE_PUSH, 32'sh7fffffff);
    send_beat(MODE_PUSH, 32'sh80000000);
    send_beat(MODE_PUSH, 32'sd0);
    send_beat(MODE_PUSH, -32'sd1);
    send_beat(MODE_PUSH, 32'sd0);
    send_beat(MODE_PUSH, 32'sd1);
    send_beat(MODE_DUMP, 32'sh5555aaaa);
    send_beat(MODE_POP, 32'shffffffff);
    send_beat(MODE_CLEAR, 32'sh12345678);
    send_beat(MODE_POP, 32'sd0);
    send_beat(MODE_DUMP, 32'sd0);
    send_beat(MODE_CLEAR, 32'sd0);

    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 6) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // fill, often past full, then read back sorted
          burst = $urandom_range(1, 20);
          repeat (burst) send_beat(MODE_PUSH, pick_word());
          send_beat(MODE_DUMP, $urandom());
          if ($urandom_range(0, 1)) send_beat(MODE_POP, $urandom());
        end
        4, 5: begin
          burst = $urandom_range(1, 18);
          repeat (burst) send_beat(MODE_POP, $urandom());
        end
        6: begin
          send_beat(MODE_CLEAR, $urandom());
          if ($urandom_range(0, 1)) send_beat(MODE_DUMP, $urandom());
        end
        default: begin
          burst = $urandom_range(1, 10);
          repeat (burst) send_beat(2'($urandom_range(0, 3)), pick_word());
        end
      endcase
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // let the checker count the results of the last beat first
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("bounded_stack_with_sorted_dump: match");
    end else begin
      $display("bounded_stack_with_sorted_dump: mismatch");
    end
    $finish;
  end

endmodule
